[hw/rtl/cvkt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvkt_pkg
// Shared types, codes and saturating Q16.16 helpers for the tracker.
// ----------------------------------------------------------------------------
package cvkt_pkg;

  // Result status codes.
  localparam logic [2:0] ST_PREDICTED = 3'd0;
  localparam logic [2:0] ST_STALE     = 3'd1;
  localparam logic [2:0] ST_RESET     = 3'd2;
  localparam logic [2:0] ST_UPDATED   = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIME_STEP  = 3'd0;
  localparam logic [2:0] CFG_NOISE_XY   = 3'd1;
  localparam logic [2:0] CFG_NOISE_Z    = 3'd2;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd3;
  localparam logic [2:0] CFG_MAX_SPEED  = 3'd4;
  localparam logic [2:0] CFG_STALE      = 3'd5;
  localparam logic [2:0] CFG_RESET      = 3'd6;

  localparam int DIV_STEPS = 80;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    LC_NONE, LC_PREDICT, LC_TRIAL, LC_COMMIT, LC_RESET
  } lane_cmd_t;

  typedef struct packed {
    logic      start;
    lane_cmd_t cmd;
  } lane_ctl_t;

  typedef struct packed {
    logic               busy;
    logic signed [63:0] sq;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } lane_stat_t;

  typedef enum logic [3:0] {
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_U0, S_U1, S_U2, S_U3, S_U4, S_U5,
    S_C1, S_C2, S_C3
  } step_t;

  typedef enum logic [1:0] {LS_IDLE, LS_ISSUE, LS_WAIT} lane_state_t;
  typedef enum logic [1:0] {MS_IDLE, MS_ACC, MS_FIN} mul_state_t;
  typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_FIN} div_state_t;
  typedef enum logic [2:0] {
    TS_IDLE, TS_PRED, TS_TRIAL, TS_GATE, TS_COMMIT, TS_OUT
  } top_state_t;

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    if (w >= 64) return v;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? S64_MIN : -$signed(m);
    return m[63] ? S64_MAX : $signed(m);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cvkt_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvkt_mul
// Sequential Q16.16 multiplier: four 32x32 partial products, then rounding.
// ----------------------------------------------------------------------------
module cvkt_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] result
);
  import cvkt_pkg::*;

  mul_state_t state, state_next;
  logic [1:0]   cnt;
  logic [63:0]  ua, ub;
  logic         neg;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [63:0]  rm;

  always_comb begin
    pp = 64'((cnt[1] ? ua[63:32] : ua[31:0]) * (cnt[0] ? ub[63:32] : ub[31:0]));
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    rnd = acc + 128'h8000;
    rm  = (|rnd[127:80]) ? {64{1'b1}} : rnd[79:16];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MS_IDLE: if (start) state_next = MS_ACC;
      MS_ACC:  if (cnt == 2'd3) state_next = MS_FIN;
      MS_FIN:  state_next = MS_IDLE;
      default: state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MS_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == MS_IDLE && start) begin
      ua  <= mag(a);
      ub  <= mag(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
      cnt <= 2'd0;
    end else if (state == MS_ACC) begin
      acc <= acc + pp_sh;
      cnt <= cnt + 2'd1;
    end else if (state == MS_FIN) begin
      result <= signed_of(rm, neg);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cvkt_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvkt_div
// Restoring Q16.16 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module cvkt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] s,
  output logic               done,
  output logic signed [63:0] result
);
  import cvkt_pkg::*;

  div_state_t state, state_next;
  logic [6:0]  cnt;
  logic [63:0] den, rem;
  logic [79:0] dvd, quo;
  logic        neg;
  logic [64:0] rem_sh, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem, dvd[79]};
    diff   = rem_sh - {1'b0, den};
    ge     = (rem_sh >= {1'b0, den});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DS_IDLE: if (start) state_next = DS_RUN;
      DS_RUN:  if (cnt == 7'(DIV_STEPS - 1)) state_next = DS_FIN;
      DS_FIN:  state_next = DS_IDLE;
      default: state_next = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DS_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == DS_IDLE && start) begin
      den <= s;
      rem <= '0;
      dvd <= {mag(a), 16'd0};
      quo <= '0;
      neg <= a[63];
      cnt <= '0;
    end else if (state == DS_RUN) begin
      rem <= ge ? diff[63:0] : rem_sh[63:0];
      dvd <= {dvd[78:0], 1'b0};
      quo <= {quo[78:0], ge};
      cnt <= cnt + 7'd1;
    end else if (state == DS_FIN) begin
      result <= signed_of((|quo[79:63]) ? {64{1'b1}} : quo[63:0], neg);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cvkt_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvkt_lane
// One axis of the tracker: state, covariance and a step sequencer.
// ----------------------------------------------------------------------------
module cvkt_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int COV_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cvkt_pkg::lane_ctl_t   ctl,
  input  logic [16:0]           time_step,
  input  logic [24:0]           process_noise,
  input  logic [24:0]           measurement_noise,
  input  logic signed [31:0]    meas,
  output cvkt_pkg::lane_stat_t  stat
);
  import cvkt_pkg::*;

  lane_state_t state, state_next;
  step_t       step, step_next;

  logic signed [DATA_WIDTH-1:0] p, v;
  logic signed [COV_WIDTH-1:0]  p11, p12, p22;
  logic signed [63:0] z, ta, tb, tc, td, k1, k2, np, nv, sq;
  logic               gate;

  logic signed [63:0] px, vx, p11x, p12x, p22x, t64, q64, r64, z_d;
  logic signed [63:0] m_a, m_b, mul_res, div_res, m_half, s_new, pos64, vel64;
  logic signed [63:0] w_pa, w_va, w_p22a, w_p11a, w_p12a, w_p11s, w_p22s, w_p12s;
  logic               mul_start, div_start, mul_done, div_done, unit_done, is_div;

  assign px   = 64'(p);
  assign vx   = 64'(v);
  assign p11x = 64'(p11);
  assign p12x = 64'(p12);
  assign p22x = 64'(p22);
  assign t64  = {47'd0, time_step};
  assign q64  = {39'd0, process_noise};
  assign r64  = {39'd0, measurement_noise};
  assign z_d  = sat_w(64'(meas), DATA_WIDTH);

  assign m_half = mul_res / 64'sd2;
  assign s_new  = add_s(p11x, r64);
  assign w_pa   = sat_w(add_s(px, mul_res), DATA_WIDTH);
  assign w_va   = sat_w(add_s(vx, mul_res), DATA_WIDTH);
  assign w_p22a = sat_w(add_s(p22x, tc), COV_WIDTH);
  assign w_p11a = sat_w(add_s(tb, m_half), COV_WIDTH);
  assign w_p12a = sat_w(add_s(ta, td), COV_WIDTH);
  assign w_p11s = sat_w(sub_s(p11x, mul_res), COV_WIDTH);
  assign w_p22s = sat_w(sub_s(p22x, mul_res), COV_WIDTH);
  assign w_p12s = sat_w(sub_s(p12x, mul_res), COV_WIDTH);
  assign pos64  = sat_w(px, 32);
  assign vel64  = sat_w(vx, 32);

  assign unit_done = mul_done | div_done;
  assign is_div    = (step == S_U1) || (step == S_U2);

  assign stat.busy = (state != LS_IDLE);
  assign stat.sq   = sq;
  assign stat.pos  = pos64[31:0];
  assign stat.vel  = vel64[31:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    m_a = t64;
    m_b = vx;
    case (step)
      S_P1: begin m_a = t64; m_b = vx; end
      S_P2: begin m_a = t64; m_b = p22x; end
      S_P3: begin m_a = t64; m_b = add_s(p12x, ta); end
      S_P4: begin m_a = t64; m_b = t64; end
      S_P5: begin m_a = q64; m_b = tc; end
      S_P6: begin m_a = tc;  m_b = t64; end
      S_P7: begin m_a = td;  m_b = t64; end
      S_U3: begin m_a = k1;  m_b = tb; end
      S_U4: begin m_a = k2;  m_b = tb; end
      S_U5: begin m_a = nv;  m_b = nv; end
      S_C1: begin m_a = k1;  m_b = p11x; end
      S_C2: begin m_a = k2;  m_b = p12x; end
      S_C3: begin m_a = k1;  m_b = p12x; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      LS_IDLE: begin
        if (ctl.start) begin
          case (ctl.cmd)
            LC_PREDICT: begin step_next = S_P1; state_next = LS_ISSUE; end
            LC_TRIAL:   begin step_next = S_U0; state_next = LS_ISSUE; end
            LC_COMMIT:  begin step_next = S_C1; state_next = LS_ISSUE; end
            default: ;
          endcase
        end
      end
      LS_ISSUE: begin
        if (step == S_U0) begin
          step_next = S_U1;
        end else if (is_div) begin
          if (gate) begin
            div_start  = 1'b1;
            state_next = LS_WAIT;
          end else begin
            step_next = (step == S_U1) ? S_U2 : S_U3;
          end
        end else begin
          mul_start  = 1'b1;
          state_next = LS_WAIT;
        end
      end
      LS_WAIT: begin
        if (unit_done) begin
          state_next = LS_ISSUE;
          case (step)
            S_P1: step_next = S_P2;
            S_P2: step_next = S_P3;
            S_P3: step_next = S_P4;
            S_P4: step_next = S_P5;
            S_P5: step_next = S_P6;
            S_P6: step_next = S_P7;
            S_U1: step_next = S_U2;
            S_U2: step_next = S_U3;
            S_U3: step_next = S_U4;
            S_U4: step_next = S_U5;
            S_C1: step_next = S_C2;
            S_C2: step_next = S_C3;
            default: state_next = LS_IDLE;
          endcase
        end
      end
      default: state_next = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
      step  <= S_P1;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p   <= '0;
      v   <= '0;
      p11 <= '0;
      p12 <= '0;
      p22 <= '0;
    end else if (state == LS_IDLE && ctl.start) begin
      if (ctl.cmd == LC_RESET) begin
        p   <= z_d[DATA_WIDTH-1:0];
        v   <= '0;
        p11 <= '0;
        p12 <= '0;
        p22 <= '0;
      end
      z <= z_d;
    end else if (state == LS_ISSUE) begin
      case (step)
        S_U0: begin
          ta   <= s_new;
          tb   <= sub_s(z, px);
          gate <= (s_new > 64'sd0);
        end
        S_U1: if (!gate) k1 <= '0;
        S_U2: if (!gate) k2 <= '0;
        default: ;
      endcase
    end else if (state == LS_WAIT && unit_done) begin
      case (step)
        S_P1: p  <= w_pa[DATA_WIDTH-1:0];
        S_P2: ta <= add_s(p12x, mul_res);
        S_P3: tb <= add_s(p11x, mul_res);
        S_P4: tc <= mul_res;
        S_P5: tc <= mul_res;
        S_P6: begin
          td  <= m_half;
          p22 <= w_p22a[COV_WIDTH-1:0];
        end
        S_P7: begin
          p11 <= w_p11a[COV_WIDTH-1:0];
          p12 <= w_p12a[COV_WIDTH-1:0];
        end
        S_U1: k1 <= div_res;
        S_U2: k2 <= div_res;
        S_U3: np <= w_pa;
        S_U4: nv <= w_va;
        S_U5: sq <= mul_res;
        S_C1: p11 <= w_p11s[COV_WIDTH-1:0];
        S_C2: p22 <= w_p22s[COV_WIDTH-1:0];
        S_C3: begin
          p12 <= w_p12s[COV_WIDTH-1:0];
          p   <= np[DATA_WIDTH-1:0];
          v   <= nv[DATA_WIDTH-1:0];
        end
        default: ;
      endcase
    end
  end

  cvkt_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (m_a),
    .b      (m_b),
    .done   (mul_done),
    .result (mul_res)
  );

  cvkt_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .a      ((step == S_U1) ? p11x : p12x),
    .s      (ta),
    .done   (div_done),
    .result (div_res)
  );

endmodule
`default_nettype wire

[hw/rtl/cvkt_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvkt_merge
// Sums the three lanes' trial speed squares and gates against the limit.
// ----------------------------------------------------------------------------
module cvkt_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] sq0,
  input  logic signed [63:0] sq1,
  input  logic signed [63:0] sq2,
  input  logic [24:0]        max_speed,
  output logic               done,
  output logic               pass
);
  import cvkt_pkg::*;

  logic [49:0]        sq_max;
  logic signed [63:0] lim, spd;
  logic               second;

  assign sq_max = 50'(max_speed * max_speed);

  always_ff @(posedge clk) begin
    lim <= {14'd0, sq_max + 50'h8000} >>> 16;
    if (rst) begin
      second <= 1'b0;
      done   <= 1'b0;
    end else begin
      second <= start;
      done   <= second;
    end
    if (start) spd <= add_s(sq0, sq1);
    if (second) pass <= (add_s(spd, sq2) <= lim);
  end

endmodule
`default_nettype wire

[hw/rtl/constant_velocity_kalman_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// constant_velocity_kalman_tracker_unit
// Three-axis constant-velocity Kalman tracker in signed Q16.16.
// ----------------------------------------------------------------------------
// The block handles one item at a time, and every item gives exactly one
// result. A tick that predicts runs seven products on each lane's
// sequential multiplier; a stale tick and a measurement that resets the
// track go straight to the output. A measurement update runs two divisions
// for the gains, three products for the trial state, a merge, and three
// more products to commit the covariance. The next input transfer may be
// taken while a finished result still waits in the output register.
module constant_velocity_kalman_tracker_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int COV_WIDTH  = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] meas_x,
  input  logic signed [31:0] meas_y,
  input  logic signed [31:0] meas_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);
  import cvkt_pkg::*;

  // Configuration registers.
  logic [16:0] time_step;
  logic [24:0] noise_xy, noise_z, meas_noise, max_speed;
  logic [15:0] stale_ticks, reset_ticks;

  top_state_t state, state_next;
  logic [15:0] tick_cnt;
  logic [2:0]  status_r;
  logic        in_acc, out_load, all_idle, merge_done, merge_pass, merge_start;

  lane_ctl_t          lane_ctl;
  lane_stat_t         lane_stat [3];
  logic signed [31:0] lane_meas [3];

  assign in_ready = (state == TS_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == TS_OUT) && (!out_valid || out_ready);
  assign all_idle = !(lane_stat[0].busy || lane_stat[1].busy || lane_stat[2].busy);

  assign lane_meas[0] = meas_x;
  assign lane_meas[1] = meas_y;
  assign lane_meas[2] = meas_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= 17'd3277;
      noise_xy    <= 25'd262144;
      noise_z     <= 25'd65536;
      meas_noise  <= 25'd6554;
      max_speed   <= 25'd262144;
      stale_ticks <= 16'd40;
      reset_ticks <= 16'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:  time_step   <= cfg_data[16:0];
        CFG_NOISE_XY:   noise_xy    <= cfg_data;
        CFG_NOISE_Z:    noise_z     <= cfg_data;
        CFG_MEAS_NOISE: meas_noise  <= cfg_data;
        CFG_MAX_SPEED:  max_speed   <= cfg_data;
        CFG_STALE:      stale_ticks <= cfg_data[15:0];
        CFG_RESET:      reset_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer: drive all three lanes unless stale, merge a trial, report.
  always_comb begin
    state_next     = state;
    lane_ctl.start = 1'b0;
    lane_ctl.cmd   = LC_NONE;
    merge_start    = 1'b0;
    unique case (state)
      TS_IDLE: begin
        if (in_acc) begin
          if (!op) begin
            if (tick_cnt < stale_ticks) begin
              lane_ctl.start = 1'b1;
              lane_ctl.cmd   = LC_PREDICT;
              state_next     = TS_PRED;
            end else begin
              state_next = TS_OUT;
            end
          end else if (tick_cnt > reset_ticks) begin
            lane_ctl.start = 1'b1;
            lane_ctl.cmd   = LC_RESET;
            state_next     = TS_OUT;
          end else begin
            lane_ctl.start = 1'b1;
            lane_ctl.cmd   = LC_TRIAL;
            state_next     = TS_TRIAL;
          end
        end
      end
      TS_PRED: if (all_idle) state_next = TS_OUT;
      TS_TRIAL: begin
        if (all_idle) begin
          merge_start = 1'b1;
          state_next  = TS_GATE;
        end
      end
      TS_GATE: begin
        if (merge_done) begin
          if (merge_pass) begin
            lane_ctl.start = 1'b1;
            lane_ctl.cmd   = LC_COMMIT;
            state_next     = TS_COMMIT;
          end else begin
            state_next = TS_OUT;
          end
        end
      end
      TS_COMMIT: if (all_idle) state_next = TS_OUT;
      TS_OUT: if (out_load) state_next = TS_IDLE;
      default: state_next = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TS_IDLE;
      tick_cnt  <= 16'hFFFF;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (!op) begin
          status_r <= (tick_cnt < stale_ticks) ? ST_PREDICTED : ST_STALE;
          if (tick_cnt != 16'hFFFF) tick_cnt <= tick_cnt + 16'd1;
        end else if (tick_cnt > reset_ticks) begin
          status_r <= ST_RESET;
          tick_cnt <= '0;
        end
      end
      if (state == TS_GATE && merge_done) begin
        status_r <= merge_pass ? ST_UPDATED : ST_REJECTED;
        if (merge_pass) tick_cnt <= '0;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Output register: payload needs no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= status_r;
      pos_x  <= lane_stat[0].pos;
      pos_y  <= lane_stat[1].pos;
      pos_z  <= lane_stat[2].pos;
      vel_x  <= lane_stat[0].vel;
      vel_y  <= lane_stat[1].vel;
      vel_z  <= lane_stat[2].vel;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cvkt_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .COV_WIDTH  (COV_WIDTH)
    ) u_lane (
      .clk               (clk),
      .rst               (rst),
      .ctl               (lane_ctl),
      .time_step         (time_step),
      .process_noise     ((i < 2) ? noise_xy : noise_z),
      .measurement_noise (meas_noise),
      .meas              (lane_meas[i]),
      .stat              (lane_stat[i])
    );
  end

  cvkt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .sq0       (lane_stat[0].sq),
    .sq1       (lane_stat[1].sq),
    .sq2       (lane_stat[2].sq),
    .max_speed (max_speed),
    .done      (merge_done),
    .pass      (merge_pass)
  );

  // Only one item is in flight at a time.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Lanes are quiet whenever the sequencer waits for input.
  a_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == TS_IDLE) |-> all_idle)
    else $error("lane busy while the sequencer is idle");

  // A reported reset or update has cleared the tick count.
  a_update_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && (status == ST_UPDATED || status == ST_RESET) |-> tick_cnt == 16'd0)
    else $error("tick count not cleared by update");

endmodule
`default_nettype wire

[test/track_estimate_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_estimate_checker
// Watches the item, result and register ports of the tracker, keeps its own
// three-axis estimate and covariance, and compares every result transfer
// with the oldest predicted estimate.
// ----------------------------------------------------------------------------
module track_estimate_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] meas_x,
  input  logic signed [31:0] meas_y,
  input  logic signed [31:0] meas_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import cvkt_pkg::*;

  localparam int EST_W = 32;
  localparam int COVAR_W = 48;
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]         st;
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } estimate_t;

  estimate_t expected_estimates[$];

  logic [16:0] t_step;
  logic [24:0] q_xy, q_z, r_meas, v_max;
  logic [15:0] stale_lim, reset_lim, tick_count;
  logic signed [63:0] pe[3], ve[3], c11[3], c12[3], c22[3];

  function automatic logic signed [63:0] clampw(logic signed [63:0] v, int w);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (v > hi) return hi;
    if (v < -hi - 64'sd1) return -hi - 64'sd1;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umag(logic signed [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] with_sign(logic [63:0] m, logic neg);
    if (neg) return m[63] ? MIN64 : -$signed(m);
    return m[63] ? MAX64 : $signed(m);
  endfunction

  // Q16.16 product, rounded half away from zero on the magnitude.
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] pr;
    logic [63:0]  r;
    pr = {64'd0, umag(a)} * {64'd0, umag(b)} + 128'h8000;
    r = (pr[127:80] != 0) ? '1 : pr[79:16];
    return with_sign(r, a[63] ^ b[63]);
  endfunction

  // Q16.16 quotient a/s for s > 0, truncated toward zero.
  function automatic logic signed [63:0] qdiv(logic signed [63:0] a, logic signed [63:0] s);
    logic [63:0]  ua;
    logic [127:0] q;
    ua = umag(a);
    if (ua / s >= 64'd1 << 47) return with_sign('1, a[63]);
    q = ({64'd0, ua} << 16) / {64'd0, s};
    return with_sign(q[63:0], a[63]);
  endfunction

  task automatic predict_axis(int i);
    logic signed [63:0] t, q, n12v, n11v, t2, n22v, p12n, p11n;
    t = $signed({47'd0, t_step});
    q = $signed({39'd0, (i < 2) ? q_xy : q_z});
    pe[i] = clampw(sadd(pe[i], qmul(t, ve[i])), EST_W);
    p12n = sadd(c12[i], qmul(t, c22[i]));
    p11n = sadd(c11[i], qmul(t, sadd(c12[i], p12n)));
    t2 = qmul(t, t);
    n22v = qmul(q, t2);
    n12v = qmul(n22v, t) / 64'sd2;
    n11v = qmul(n12v, t) / 64'sd2;
    c11[i] = clampw(sadd(p11n, n11v), COVAR_W);
    c12[i] = clampw(sadd(p12n, n12v), COVAR_W);
    c22[i] = clampw(sadd(c22[i], n22v), COVAR_W);
  endtask

  task automatic advance_track(logic o, logic signed [31:0] mx, logic signed [31:0] my,
                               logic signed [31:0] mz, output estimate_t e);
    logic signed [63:0] z[3], k1[3], k2[3], np[3], nv[3];
    logic signed [63:0] s, d, spd, lim, o11, o12;
    logic [2:0] st;
    z[0] = mx; z[1] = my; z[2] = mz;
    if (!o) begin
      if (tick_count < stale_lim) begin
        for (int i = 0; i < 3; i++) predict_axis(i);
        st = ST_PREDICTED;
      end else begin
        st = ST_STALE;
      end
      if (tick_count != 16'hFFFF) tick_count++;
    end else if (tick_count > reset_lim) begin
      for (int i = 0; i < 3; i++) begin
        pe[i] = z[i]; ve[i] = 0; c11[i] = 0; c12[i] = 0; c22[i] = 0;
      end
      tick_count = 0;
      st = ST_RESET;
    end else begin
      spd = 0;
      for (int i = 0; i < 3; i++) begin
        s = sadd(c11[i], $signed({39'd0, r_meas}));
        d = ssub(z[i], pe[i]);
        if (s > 0) begin
          k1[i] = qdiv(c11[i], s);
          k2[i] = qdiv(c12[i], s);
        end else begin
          k1[i] = 0; k2[i] = 0;
        end
        np[i] = clampw(sadd(pe[i], qmul(k1[i], d)), EST_W);
        nv[i] = clampw(sadd(ve[i], qmul(k2[i], d)), EST_W);
        spd = sadd(spd, qmul(nv[i], nv[i]));
      end
      lim = qmul($signed({39'd0, v_max}), $signed({39'd0, v_max}));
      if (spd <= lim) begin
        for (int i = 0; i < 3; i++) begin
          o11 = c11[i]; o12 = c12[i];
          pe[i] = np[i]; ve[i] = nv[i];
          c11[i] = clampw(ssub(o11, qmul(k1[i], o11)), COVAR_W);
          c12[i] = clampw(ssub(o12, qmul(k1[i], o12)), COVAR_W);
          c22[i] = clampw(ssub(c22[i], qmul(k2[i], o12)), COVAR_W);
        end
        tick_count = 0;
        st = ST_UPDATED;
      end else begin
        st = ST_REJECTED;
      end
    end
    e.st = st;
    e.px = clampw(pe[0], 32); e.py = clampw(pe[1], 32); e.pz = clampw(pe[2], 32);
    e.vx = clampw(ve[0], 32); e.vy = clampw(ve[1], 32); e.vz = clampw(ve[2], 32);
  endtask

  always @(posedge clk) begin
    estimate_t want, got;
    if (rst) begin
      t_step = 17'd3277; q_xy = 25'd262144; q_z = 25'd65536; r_meas = 25'd6554;
      v_max = 25'd262144; stale_lim = 16'd40; reset_lim = 16'd60;
      tick_count = 16'hFFFF;
      for (int i = 0; i < 3; i++) begin
        pe[i] = 0; ve[i] = 0; c11[i] = 0; c12[i] = 0; c22[i] = 0;
      end
      expected_estimates.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:  t_step = cfg_data[16:0];
          CFG_NOISE_XY:   q_xy = cfg_data;
          CFG_NOISE_Z:    q_z = cfg_data;
          CFG_MEAS_NOISE: r_meas = cfg_data;
          CFG_MAX_SPEED:  v_max = cfg_data;
          CFG_STALE:      stale_lim = cfg_data[15:0];
          CFG_RESET:      reset_lim = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{status, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z};
        if (expected_estimates.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = expected_estimates.pop_front();
          if (want.st !== got.st || want.px !== got.px || want.py !== got.py ||
              want.pz !== got.pz || want.vx !== got.vx || want.vy !== got.vy ||
              want.vz !== got.vz) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_track(op, meas_x, meas_y, meas_z, want);
        expected_estimates.push_back(want);
      end
      pending = expected_estimates.size();
    end
  end

endmodule

[test/tb_constant_velocity_kalman_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_constant_velocity_kalman_tracker_unit
// Drives ticks and position measurements into the tracker under several
// register settings, with random gaps on both channels, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_constant_velocity_kalman_tracker_unit;
  import cvkt_pkg::*;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_MEAS = 1'b1;
  localparam int         IDLE_PCT = 34;
  localparam int         RANDOM_PER_PHASE = 185;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         DRAIN_CYCLES = 300;

  logic               clk, rst;
  logic               in_valid, in_ready, op;
  logic signed [31:0] meas_x, meas_y, meas_z;
  logic               out_valid, out_ready;
  logic [2:0]         status;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [24:0]        cfg_data;
  int                 errors, pending;

  // Shared stimulus controls: quiet turns idling off on both sides, and the
  // sent count lets the receiver decide when to start its long hold-off.
  bit                 quiet;
  int                 n_sent;
  int                 idle_run;

  // Model of the target that the well-formed measurements follow.
  longint             tgt_p[3], tgt_v[3];
  longint             cur_t;

  constant_velocity_kalman_tracker_unit dut (
    .clk, .rst, .in_valid, .in_ready, .op, .meas_x, .meas_y, .meas_z,
    .out_valid, .out_ready, .status, .pos_x, .pos_y, .pos_z,
    .vel_x, .vel_y, .vel_z, .cfg_we, .cfg_index, .cfg_data
  );

  track_estimate_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .op, .meas_x, .meas_y, .meas_z,
    .out_valid, .out_ready, .status, .pos_x, .pos_y, .pos_z,
    .vel_x, .vel_y, .vel_z, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The watchdog counts cycles without any transfer on either channel. Every
  // legal pause (a long update, the receiver hold-off, a drain) is far shorter.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // The receiver stalls at random, except in quiet stretches. Once, after a
  // few hundred items, it holds off for a long run so that a result sits in
  // the output register and the block has to stop taking input transfers.
  initial begin
    bit hold_done;
    int hold_left;
    hold_done = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= 400) begin
        hold_done = 1;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One input transfer. It is called at a falling edge and returns at the
  // falling edge after the transfer, so valid only ever gets one assignment
  // per time step and stays high between back-to-back items.
  task automatic send(logic o, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    meas_x <= x;
    meas_y <= y;
    meas_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_TIME_STEP) cur_t = val[16:0];
    @(negedge clk);
  endtask

  // Registers change only while the block is idle: wait for every expected
  // result, then give the block some extra cycles before writing.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [24:0] t, logic [24:0] qxy, logic [24:0] qz,
                          logic [24:0] r, logic [24:0] vmax, logic [24:0] stl,
                          logic [24:0] rsl);
    drain();
    write_reg(CFG_TIME_STEP, t);
    write_reg(CFG_NOISE_XY, qxy);
    write_reg(CFG_NOISE_Z, qz);
    write_reg(CFG_MEAS_NOISE, r);
    write_reg(CFG_MAX_SPEED, vmax);
    write_reg(CFG_STALE, stl);
    write_reg(CFG_RESET, rsl);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic new_target;
    for (int i = 0; i < 3; i++) begin
      tgt_p[i] = longint'($urandom_range(0, 13107200)) - 64'sd6553600;
      tgt_v[i] = longint'($urandom_range(0, 262144)) - 64'sd131072;
    end
  endtask

  // Mostly a tick or a noisy sighting of the modelled target; now and then a
  // measurement with fully random bits, which usually fails the speed gate.
  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r == 0) new_target();
      if (r < 55) begin
        for (int i = 0; i < 3; i++) tgt_p[i] += (tgt_v[i] * cur_t) >>> 16;
        send(OP_TICK, $urandom, $urandom, $urandom);
      end else if (r < 88) begin
        send(OP_MEAS,
             clip32(tgt_p[0] + longint'($urandom_range(0, 4000)) - 2000),
             clip32(tgt_p[1] + longint'($urandom_range(0, 4000)) - 2000),
             clip32(tgt_p[2] + longint'($urandom_range(0, 4000)) - 2000));
      end else begin
        send(OP_MEAS, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 0;
    n_sent = 0;
    cur_t = 3277;
    in_valid = 1'b0;
    op = OP_TICK;
    meas_x = '0;
    meas_y = '0;
    meas_z = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TIME_STEP;
    cfg_data = '0;
    new_target();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings. The tick count starts saturated,
    // so the first tick is skipped as stale and the first measurement resets.
    send(OP_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send(OP_MEAS, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send(OP_TICK, '0, '0, '0);
    send(OP_TICK, '1, '1, '1);
    send(OP_MEAS, 32'sh7FFF_FF00, 32'sh8000_0100, 32'sd65536);
    // A jump across the whole range trips the speed gate.
    send(OP_MEAS, 32'sd0, 32'sd0, 32'sh8000_0000);
    send(OP_MEAS, -32'sd1, 32'sd1, 32'sh7FFF_FFFF);
    for (int k = 0; k < 4; k++) send(OP_TICK, '0, '0, '0);
    send(OP_MEAS, 32'sh7FFF_FFF0, 32'sh8000_0010, 32'sd70000);
    drain();
    write_reg(CFG_UNUSED, '1);
    cfg_we <= 1'b0;

    // Zero measurement noise makes the innovation variance the bare position
    // covariance; if that is zero, both gains are zero and the estimate stays.
    set_regs(25'd65536, 25'd16777216, 25'd16777216, 25'd0, 25'd16777216,
             25'd65535, 25'd65535);
    send(OP_MEAS, 32'sd1000, -32'sd1000, 32'sd5);
    send(OP_MEAS, 32'sd2000, -32'sd2000, 32'sd7);
    for (int k = 0; k < 3; k++) send(OP_TICK, '0, '0, '0);
    send(OP_MEAS, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    random_items(RANDOM_PER_PHASE);

    // Smallest nonzero step, no process noise, a measurement noise of 256.0 and a
    // zero speed limit: ticks are always stale, and a measurement after a tick resets.
    set_regs(25'd1, 25'd0, 25'd0, 25'd16777216, 25'd0, 25'd0, 25'd0);
    random_items(RANDOM_PER_PHASE);

    set_regs(25'($urandom), 25'($urandom), 25'($urandom), 25'($urandom), 25'($urandom),
             25'($urandom_range(0, 80)), 25'($urandom_range(0, 120)));
    random_items(RANDOM_PER_PHASE);

    // A stretch without idling on either side.
    set_regs(25'd3277, 25'd262144, 25'd65536, 25'd6554, 25'd1048576, 25'd20, 25'd30);
    quiet = 1;
    random_items(RANDOM_PER_PHASE);
    quiet = 0;

    set_regs(25'd6554, 25'd65536, 25'd32768, 25'd65536, 25'd524288, 25'd12, 25'd25);
    random_items(RANDOM_PER_PHASE);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cvkt_pkg.sv
hw/rtl/cvkt_mul.sv
hw/rtl/cvkt_div.sv
hw/rtl/cvkt_lane.sv
hw/rtl/cvkt_merge.sv
hw/rtl/constant_velocity_kalman_tracker_unit.sv
test/track_estimate_checker.sv
test/tb_constant_velocity_kalman_tracker_unit.sv
